/* rtl/wbps_pkg.sv */
// wbps_pkg: shared types, constants and register codes for the wildcard
// byte pattern scan unit. Used by every module in rtl; depends on nothing.
`default_nettype none

package wbps_pkg;

  localparam int MAX_PATTERN      = 32;
  localparam int POSITION_BITS    = 32;
  localparam int LEN_BITS         = $clog2(MAX_PATTERN + 1);
  localparam int IDX_BITS         = $clog2(MAX_PATTERN);
  localparam int WINDOW_DEPTH     = MAX_PATTERN - 1;
  localparam int PATTERN_WORDS    = 4;
  localparam int CFG_INDEX_BITS   = 3;
  localparam int CFG_DATA_BITS    = 64;
  localparam int LENGTH_REG_BITS  = 6;
  localparam int MASK_REG_BITS    = 32;
  localparam int MATCH_START_BITS = 32;
  localparam int TALLY_BITS       = 16;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PATTERN_LENGTH = 3'd0,
    REG_PATTERN_0_7    = 3'd1,
    REG_PATTERN_8_15   = 3'd2,
    REG_PATTERN_16_23  = 3'd3,
    REG_PATTERN_24_31  = 3'd4,
    REG_WILDCARD_MASK  = 3'd5,
    REG_REPORT_ALL     = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic                        match_hit;
    logic [MATCH_START_BITS-1:0] match_start;
    logic [TALLY_BITS-1:0]       matches_so_far;
    logic                        end_of_region;
  } out_item_t;

  typedef struct packed {
    logic [LENGTH_REG_BITS-1:0]                   pattern_length;
    logic [PATTERN_WORDS-1:0][CFG_DATA_BITS-1:0]  pattern_words;
    logic [MASK_REG_BITS-1:0]                     wildcard_mask;
    logic                                         report_all;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/wbps_cfg_regs.sv */
// wbps_cfg_regs: configuration register file written over the cfg channel.
// Depends on wbps_pkg for the register codes and the cfg_t bundle.
`default_nettype none

module wbps_cfg_regs (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [wbps_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [wbps_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output wbps_pkg::cfg_t                             cfg
);

  wbps_pkg::cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pattern_length <= wbps_pkg::LENGTH_REG_BITS'(1);
      regs.pattern_words  <= '0;
      regs.wildcard_mask  <= '0;
      regs.report_all     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wbps_pkg::REG_PATTERN_LENGTH:
          regs.pattern_length <= cfg_data[wbps_pkg::LENGTH_REG_BITS-1:0];
        wbps_pkg::REG_PATTERN_0_7:   regs.pattern_words[0] <= cfg_data;
        wbps_pkg::REG_PATTERN_8_15:  regs.pattern_words[1] <= cfg_data;
        wbps_pkg::REG_PATTERN_16_23: regs.pattern_words[2] <= cfg_data;
        wbps_pkg::REG_PATTERN_24_31: regs.pattern_words[3] <= cfg_data;
        wbps_pkg::REG_WILDCARD_MASK:
          regs.wildcard_mask <= cfg_data[wbps_pkg::MASK_REG_BITS-1:0];
        wbps_pkg::REG_REPORT_ALL:    regs.report_all <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/wbps_matcher.sv */
// wbps_matcher: byte window, stream position and tally, plus the parallel
// wildcard compare that forms one result per step. Depends on wbps_pkg.
`default_nettype none

module wbps_matcher (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire wbps_pkg::cfg_t      cfg,
  input  wire logic                step,
  input  wire wbps_pkg::in_item_t  item,
  output wbps_pkg::out_item_t      result
);

  logic [7:0]                          byte_window [wbps_pkg::WINDOW_DEPTH];
  logic [wbps_pkg::POSITION_BITS-1:0]  stream_position;
  logic [wbps_pkg::TALLY_BITS-1:0]     match_tally;
  logic                                first_seen;
  logic [wbps_pkg::LEN_BITS-1:0]       window_fill;

  logic [wbps_pkg::LEN_BITS-1:0]       len;
  logic [7:0]                          taps [wbps_pkg::MAX_PATTERN];
  logic                                enough;
  logic                                match;
  logic                                hit;
  logic [wbps_pkg::TALLY_BITS-1:0]     match_tally_next;
  logic [wbps_pkg::POSITION_BITS-1:0]  start;

  // clamp the length register into 1..MAX_PATTERN
  always_comb begin
    if (cfg.pattern_length == '0) begin
      len = wbps_pkg::LEN_BITS'(1);
    end else if (cfg.pattern_length > wbps_pkg::LENGTH_REG_BITS'(wbps_pkg::MAX_PATTERN)) begin
      len = wbps_pkg::LEN_BITS'(wbps_pkg::MAX_PATTERN);
    end else begin
      len = wbps_pkg::LEN_BITS'(cfg.pattern_length);
    end
  end

  // tap k holds the byte of age k, tap 0 is the current byte
  always_comb begin
    taps[0] = item.data_byte;
    for (int k = 1; k < wbps_pkg::MAX_PATTERN; k++) begin
      taps[k] = byte_window[k-1];
    end
  end

  assign enough = ({1'b0, window_fill} + (wbps_pkg::LEN_BITS + 1)'(1)) >= {1'b0, len};

  always_comb begin
    logic [wbps_pkg::LEN_BITS-1:0] age;
    logic [7:0]                    pat;
    match = enough;
    for (int i = 0; i < wbps_pkg::MAX_PATTERN; i++) begin
      age = len - wbps_pkg::LEN_BITS'(1) - wbps_pkg::LEN_BITS'(i);
      pat = cfg.pattern_words[i / 8][(i % 8) * 8 +: 8];
      if ((wbps_pkg::LEN_BITS'(i) < len) && !cfg.wildcard_mask[i]) begin
        if (taps[age[wbps_pkg::IDX_BITS-1:0]] != pat) begin
          match = 1'b0;
        end
      end
    end
  end

  assign hit   = match && (cfg.report_all || !first_seen);
  assign start = stream_position
               - wbps_pkg::POSITION_BITS'(len - wbps_pkg::LEN_BITS'(1));

  always_comb begin
    match_tally_next = match_tally;
    if (match && (match_tally != '1)) begin
      match_tally_next = match_tally + wbps_pkg::TALLY_BITS'(1);
    end
  end

  always_comb begin
    result.match_hit      = hit;
    result.match_start    = hit ? wbps_pkg::MATCH_START_BITS'(start) : '0;
    result.matches_so_far = match_tally_next;
    result.end_of_region  = item.last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.last_byte)) begin
      for (int k = 0; k < wbps_pkg::WINDOW_DEPTH; k++) begin
        byte_window[k] <= '0;
      end
      stream_position <= '0;
      match_tally     <= '0;
      first_seen      <= 1'b0;
      window_fill     <= '0;
    end else if (step) begin
      byte_window[0] <= item.data_byte;
      for (int k = 1; k < wbps_pkg::WINDOW_DEPTH; k++) begin
        byte_window[k] <= byte_window[k-1];
      end
      stream_position <= stream_position + wbps_pkg::POSITION_BITS'(1);
      match_tally     <= match_tally_next;
      first_seen      <= first_seen || match;
      if (window_fill != wbps_pkg::LEN_BITS'(wbps_pkg::MAX_PATTERN)) begin
        window_fill <= window_fill + wbps_pkg::LEN_BITS'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/wildcard_byte_pattern_scan_unit.sv */
// Wildcard byte pattern scan unit: input register, window compare, result register.
// Path: a byte accepted into the input register passes through the window compare
// and its result is loaded into the result register when the result side is free.
// Throughput: one byte per cycle while result_stall is low (combinational compare).
// Reset: clears both pipeline valid bits and the scan state; registers take their
// reset values (pattern_length 1, all others 0). Depends on wbps_pkg.
`default_nettype none

module wildcard_byte_pattern_scan_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                byte_valid,
  output logic                                     byte_stall,
  input  wire wbps_pkg::in_item_t                  byte_item,
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output wbps_pkg::out_item_t                      result_item,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [wbps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [wbps_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  wbps_pkg::cfg_t      cfg;
  wbps_pkg::in_item_t  hold_item;
  logic                hold_valid;
  wbps_pkg::out_item_t result;
  logic                result_free;
  logic                step;
  logic                accept;

  wbps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wbps_matcher u_match (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (step),
    .item   (hold_item),
    .result (result)
  );

  assign result_free = !result_valid || !result_stall;
  assign step        = hold_valid && result_free;
  assign byte_stall  = hold_valid && !result_free;
  assign accept      = byte_valid && !byte_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (step) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_item <= byte_item;
    end
  end

  // result register, reloads as soon as the held transaction is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result_item <= result;
    end
  end

endmodule

`default_nettype wire
